// ----- rtl/core/dvad_pkg.sv -----
// ----------------------------------------------------------------------------
// dvad_pkg
// Shared types and constants of the masked 2x2 depth mean downsampler.
// ----------------------------------------------------------------------------
package dvad_pkg;

  // stream payload widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // row counter and height limit
  localparam int ROW_W = 12;
  localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;

  // op queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic {
    OP_STORE = 1'b0,  // even row: park pair sum/count in the line store
    OP_EMIT  = 1'b1   // odd row: combine with line store, produce a result
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic       last;
    logic [1:0] cnt;
  } op_ctl_t;

endpackage

// ----- rtl/core/dvad_if.sv -----
// ----------------------------------------------------------------------------
// dvad stream interfaces
// Valid/ready channels for input depth pixels and averaged output pixels.
// ----------------------------------------------------------------------------
interface dvad_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_value;

  modport source (output valid, output depth_value, input ready);
  modport sink   (input valid, input depth_value, output ready);
endinterface

interface dvad_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_depth;
  logic        last_of_frame;

  modport source (output valid, output out_depth, output last_of_frame, input ready);
  modport sink   (input valid, input out_depth, input last_of_frame, output ready);
endinterface

// ----- rtl/core/depth_valid_average_downsample_unit.sv -----
// ----------------------------------------------------------------------------
// depth_valid_average_downsample_unit
// Half-size depth image: mean of the nonzero pixels of every 2x2 block.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle in raster order and sustains that rate as long as
// the output side takes results. A result is produced for each odd-row,
// odd-column pixel inside the even-sized frame area; its op passes through
// the op queue and the s1, s2 and output registers; the front keeps going
// while the back stalls until the 4-entry op queue fills. The line store holds
// MAX_WIDTH/2 entries and has no clearing pass: every entry is written by the
// even row before the odd row reads it. frame_width and frame_height are
// clamped to [2, MAX_WIDTH] and [2, 4096]; a trailing odd column or row is
// consumed without output. Write the registers only while the block is idle.
module depth_valid_average_downsample_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int DEPTH_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dvad_in_if.sink                           pix_i,
  dvad_out_if.source                        avg_o,
  input  logic                              cfg_we_i,
  input  logic [dvad_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dvad_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import dvad_pkg::*;

  localparam int PixW = (DEPTH_BITS < IN_W) ? DEPTH_BITS : IN_W;
  localparam int IdxW = $clog2(MAX_WIDTH) - 1;
  localparam int OpW  = $bits(op_ctl_t) + IdxW + PixW + 1;

  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            q_push, q_pop, q_full, q_empty;
  logic [OpW-1:0]  q_wr_op, q_rd_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  dvad_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DEPTH_BITS (DEPTH_BITS),
    .OpW        (OpW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix            (pix_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .op_o           (q_wr_op)
  );

  dvad_queue #(
    .Width (OpW)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr_op),
    .pop_i     (q_pop),
    .rd_data_o (q_rd_op),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  dvad_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DEPTH_BITS (DEPTH_BITS),
    .OpW        (OpW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .op_i      (q_rd_op),
    .pop_o     (q_pop),
    .avg       (avg_o)
  );

endmodule

// ----- rtl/core/dvad_queue.sv -----
// ----------------------------------------------------------------------------
// dvad_queue
// Small FIFO of block ops between the pixel front and the averaging back.
// ----------------------------------------------------------------------------
module dvad_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);
  import dvad_pkg::*;

  logic [Width-1:0]  slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- rtl/core/dvad_front.sv -----
// ----------------------------------------------------------------------------
// dvad_front
// Accepts pixels, tracks column/row position, pairs even/odd columns and
// queues one op per pixel pair inside the used (even) frame area.
// ----------------------------------------------------------------------------
module dvad_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int DEPTH_BITS = 16,
  parameter int OpW        = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dvad_in_if.sink                     pix,
  input  logic [dvad_pkg::FW_W-1:0]   frame_width_i,
  input  logic [dvad_pkg::FH_W-1:0]   frame_height_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output logic [OpW-1:0]              op_o
);
  import dvad_pkg::*;

  localparam int PixW = (DEPTH_BITS < IN_W) ? DEPTH_BITS : IN_W;
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int IdxW = ColW - 1;
  localparam int WW   = (ColW + 1 > FW_W) ? ColW + 1 : FW_W;

  typedef struct packed {
    op_ctl_t         ctl;
    logic [IdxW-1:0] idx;
    logic [PixW:0]   sum;
  } op_t;

  logic [ColW-1:0]  col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PixW-1:0]  held_q, held_d;

  logic [WW-1:0]    fw_ext, w, used_w, c_ext;
  logic [FH_W-1:0]  h, used_h, r_ext;
  logic [PixW-1:0]  d;
  logic             accept, in_area;
  op_t              op;

  assign d      = pix.depth_value[PixW-1:0];
  assign fw_ext = WW'(frame_width_i);

  always_comb begin
    if (fw_ext < WW'(2)) begin
      w = WW'(2);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    if (frame_height_i < FH_W'(2)) begin
      h = FH_W'(2);
    end else if (frame_height_i > MAX_HEIGHT) begin
      h = MAX_HEIGHT;
    end else begin
      h = frame_height_i;
    end
  end

  assign used_w  = {w[WW-1:1], 1'b0};
  assign used_h  = {h[FH_W-1:1], 1'b0};
  assign c_ext   = WW'(col_q);
  assign r_ext   = FH_W'(row_q);
  assign in_area = (c_ext < used_w) && (r_ext < used_h);

  assign pix.ready = !q_full_i;
  assign accept    = pix.valid && !q_full_i;
  assign push_o    = accept && in_area && col_q[0];

  always_comb begin
    op.ctl.kind = row_q[0] ? OP_EMIT : OP_STORE;
    op.ctl.last = (r_ext == used_h - 1'b1) && (c_ext == used_w - 1'b1);
    op.ctl.cnt  = 2'((held_q != '0)) + 2'((d != '0));
    op.idx      = col_q[ColW-1:1];
    op.sum      = (PixW+1)'(held_q) + (PixW+1)'(d);
  end
  assign op_o = op;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (accept) begin
      if (in_area && !col_q[0]) begin
        held_d = d;
      end
      // a counter at or past the last index wraps, also after a size change
      if (c_ext >= w - 1'b1) begin
        col_d = '0;
        row_d = (r_ext >= h - 1'b1) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- rtl/core/dvad_back.sv -----
// ----------------------------------------------------------------------------
// dvad_back
// Executes queued ops: line store write for even rows; for odd rows a line
// store read, block sum, rounding and divide by the valid count.
// ----------------------------------------------------------------------------
module dvad_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int DEPTH_BITS = 16,
  parameter int OpW        = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  logic [OpW-1:0] op_i,
  output logic           pop_o,
  dvad_out_if.source     avg
);
  import dvad_pkg::*;

  localparam int PixW  = (DEPTH_BITS < IN_W) ? DEPTH_BITS : IN_W;
  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int IdxW  = ColW - 1;
  localparam int LineD = MAX_WIDTH / 2;
  localparam int XW    = PixW + 2;
  // x / 3 == (x * DivM) >> DivS, exact for x below 2**XW
  localparam int DivS  = XW + 1;
  localparam int DivM  = ((1 << DivS) + 2) / 3;
  localparam int PW    = XW + DivS;

  typedef struct packed {
    op_ctl_t         ctl;
    logic [IdxW-1:0] idx;
    logic [PixW:0]   sum;
  } op_t;

  typedef struct packed {
    logic [PixW:0] sum;
    logic [1:0]    cnt;
  } line_t;

  op_t             op;
  line_t           line_mem [LineD];
  line_t           rd_q;
  logic            adv, pop;

  logic            s1_v_q;
  logic [PixW:0]   s1_sum_q;
  logic [1:0]      s1_cnt_q;
  logic            s1_last_q;

  logic [XW-1:0]   tot_sum, x;
  logic [2:0]      tot_cnt;
  logic [DivS-1:0] recip;

  logic            s2_v_q;
  logic [XW-1:0]   s2_x_q;
  logic [PW-1:0]   s2_prod_q;
  logic [2:0]      s2_cnt_q;
  logic            s2_last_q;

  logic [XW-1:0]   quot3;
  logic [PixW-1:0] mean;

  logic            out_v_q;
  logic [OUT_W-1:0] out_depth_q;
  logic            out_last_q;

  assign op    = op_i;
  assign adv   = !out_v_q || avg.ready;
  assign pop   = !q_empty_i && adv;
  assign pop_o = pop;

  // line store: one write or one read per popped op
  always_ff @(posedge clk_i) begin
    if (pop && op.ctl.kind == OP_STORE) begin
      line_mem[op.idx] <= '{sum: op.sum, cnt: op.ctl.cnt};
    end
    if (pop && op.ctl.kind == OP_EMIT) begin
      rd_q <= line_mem[op.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop && op.ctl.kind == OP_EMIT;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  assign tot_sum = XW'(s1_sum_q) + XW'(rd_q.sum);
  assign tot_cnt = 3'(s1_cnt_q) + 3'(rd_q.cnt);
  assign x       = tot_sum + XW'(tot_cnt[2:1]);
  assign recip   = DivS'(DivM);

  assign quot3 = s2_prod_q[PW-1:DivS];

  always_comb begin
    case (s2_cnt_q)
      3'd1:    mean = s2_x_q[PixW-1:0];
      3'd2:    mean = s2_x_q[PixW:1];
      3'd3:    mean = quot3[PixW-1:0];
      3'd4:    mean = s2_x_q[PixW+1:2];
      default: mean = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sum_q    <= op.sum;
      s1_cnt_q    <= op.ctl.cnt;
      s1_last_q   <= op.ctl.last;
      s2_x_q      <= x;
      s2_prod_q   <= PW'(x) * PW'(recip);
      s2_cnt_q    <= tot_cnt;
      s2_last_q   <= s1_last_q;
      out_depth_q <= OUT_W'(mean);
      out_last_q  <= s2_last_q;
    end
  end

  assign avg.valid         = out_v_q;
  assign avg.out_depth     = out_depth_q;
  assign avg.last_of_frame = out_last_q;

endmodule

// ----- rtl/core/dvad_checker.sv -----
// ----------------------------------------------------------------------------
// dvad_checker
// Port-level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module dvad_checker #(
  parameter int DEPTH_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pix_ready_i,
  input logic        avg_valid_i,
  input logic        avg_ready_i,
  input logic [15:0] avg_depth_i,
  input logic        avg_last_i
);
  import dvad_pkg::*;

  localparam int PixW = (DEPTH_BITS < IN_W) ? DEPTH_BITS : IN_W;

  // a stalled result stays offered
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_valid_i && !avg_ready_i |=> avg_valid_i)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_valid_i && !avg_ready_i |=> $stable(avg_depth_i) && $stable(avg_last_i))
    else $error("result changed while stalled");

  // a mean never exceeds the pixel width
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_valid_i |-> (avg_depth_i >> PixW) == '0)
    else $error("mean out of pixel range");

  // with the back running freely, the op queue must have room again
  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !avg_valid_i && $past(!avg_valid_i) |-> pix_ready_i)
    else $error("input blocked while back side idle");

endmodule

bind depth_valid_average_downsample_unit dvad_checker #(
  .DEPTH_BITS (DEPTH_BITS)
) u_dvad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_ready_i (pix_i.ready),
  .avg_valid_i (avg_o.valid),
  .avg_ready_i (avg_o.ready),
  .avg_depth_i (avg_o.out_depth),
  .avg_last_i  (avg_o.last_of_frame)
);
